// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, held off while reset is low
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while reset is low
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- design/cossim_pkg.sv -----
// ----------------------------------------------------------------------------
// cossim_pkg
// types, widths and helpers for the streaming cosine similarity block
// ----------------------------------------------------------------------------
`default_nettype none

package cossim_pkg;

  // element handling
  localparam int FieldBits = 16;
  localparam int ElemBits  = 16;
  localparam int ElemEff   = (ElemBits < FieldBits) ? ElemBits : FieldBits;

  // accumulator widths
  localparam int DotBits  = 43;
  localparam int NormBits = 42;

  // shared multiplier and long products
  localparam int LimbBits = 32;
  localparam int ProdBits = 2 * LimbBits;
  localparam int PBits    = 2 * NormBits;           // norm_a * norm_b
  localparam int RBits    = 2 * DotBits;            // dot magnitude squared
  localparam int AccBits  = 2 * FieldBits + PBits;  // odd^2 * norm product

  // ratio search
  localparam int KBits      = 16;
  localparam int KMax       = 32768;
  localparam int SatMax     = 32767;
  localparam int BitIdxBits = 4;
  localparam int StepBits   = 3;
  localparam int NumProdPR  = 4;                    // 2x2 limb products
  localparam int NumProdL   = 3;                    // 1x3 limb products

  typedef struct packed {
    logic signed [FieldBits-1:0] elem_a;
    logic signed [FieldBits-1:0] elem_b;
    logic                        last;
  } cossim_in_t;

  typedef struct packed {
    logic signed [FieldBits-1:0] similarity;
    logic                        zero_norm;
  } cossim_out_t;

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_CHECK,
    ST_MUL_P,
    ST_LATCH_P,
    ST_MUL_R,
    ST_LATCH_R,
    ST_SQUARE,
    ST_MUL_L,
    ST_COMPARE,
    ST_DONE
  } cossim_state_e;

  // operand pair and weight for one pass of the shared multiplier
  typedef enum logic [3:0] {
    MO_P00,
    MO_P01,
    MO_P10,
    MO_P11,
    MO_R00,
    MO_R01,
    MO_R10,
    MO_R11,
    MO_L0,
    MO_L1,
    MO_L2
  } cossim_mul_op_e;

  typedef struct packed {
    logic                  acc_en;
    logic                  clr_sums;
    logic                  latch_mag;
    logic                  clr_k;
    logic                  mul_en;
    cossim_mul_op_e        mul_op;
    logic                  clr_acc;
    logic                  latch_p;
    logic                  latch_r;
    logic                  latch_sq;
    logic                  compare;
    logic [BitIdxBits-1:0] bit_idx;
    logic                  load_out;
  } cossim_cmd_t;

  typedef struct packed {
    logic zero_norm;
    logic out_free;
  } cossim_stat_t;

  // low ElemEff bits of a field, sign-extended
  function automatic logic signed [FieldBits-1:0] sext_elem(input logic [FieldBits-1:0] raw);
    logic signed [FieldBits-1:0] t;
    t = $signed(raw << (FieldBits - ElemEff));
    return t >>> (FieldBits - ElemEff);
  endfunction

endpackage

`default_nettype wire

// ----- design/cosine_similarity_stream.sv -----
// ----------------------------------------------------------------------------
// cosine_similarity_stream
// streaming cosine similarity of two signed vectors, result in signed q1.15
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake                payload
//   input     in   in_valid_i / in_stall_o   elem_a, elem_b, last
//   output    out  out_valid_o / out_stall_i similarity, zero_norm
//
// one input beat per cycle while the vectors are being accumulated
// after the beat marked last the input stalls for two 2x2 limb products
// on the shared 32x32 multiplier, then a 16-step bitwise search (both
// skipped on a zero norm), and for as long as the previous result still
// sits stalled in the output register
// reset clears the sums and the sequencer; no clearing pass is needed
// the output register lets the next vector stream in while a result waits
// ----------------------------------------------------------------------------
`default_nettype none

module cosine_similarity_stream (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input beats
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  cossim_pkg::cossim_in_t  in_data_i,
  // result beats
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output cossim_pkg::cossim_out_t out_data_o
);

  cossim_pkg::cossim_cmd_t  cmd;
  cossim_pkg::cossim_stat_t stat;

  // sequencer: owns the input stall, steps the multiplier and the search
  cossim_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // datapath: exact sums, long products and the registered result
  cossim_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- design/cossim_dp.sv -----
// ----------------------------------------------------------------------------
// cossim_dp
// accumulators, shared 32x32 multiplier, ratio search registers and result
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cossim_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cossim_pkg::cossim_in_t   in_data_i,
  input  cossim_pkg::cossim_cmd_t  cmd_i,
  input  logic                     out_stall_i,
  output cossim_pkg::cossim_stat_t stat_o,
  output logic                     out_valid_o,
  output cossim_pkg::cossim_out_t  out_data_o
);

  localparam int FB = cossim_pkg::FieldBits;
  localparam int DB = cossim_pkg::DotBits;
  localparam int NB = cossim_pkg::NormBits;
  localparam int LB = cossim_pkg::LimbBits;
  localparam int AB = cossim_pkg::AccBits;
  localparam int KB = cossim_pkg::KBits;

  logic signed [FB-1:0]   a, b;
  logic signed [2*FB-1:0] pab, paa, pbb;

  logic [DB-1:0] dot_q, dot_d;
  logic [NB-1:0] na_q, na_d, nb_q, nb_d;
  logic [DB-1:0] mag_q, mag_d;
  logic          neg;

  logic [cossim_pkg::PBits-1:0] p_q;
  logic [cossim_pkg::RBits-1:0] r_q;
  logic [2*FB-1:0]              sq_q, sq_d;
  logic [KB-1:0]                k_q, k_d, cand;
  logic [KB:0]                  odd_w;
  logic                         cand_ok, fits;

  logic [LB-1:0]                   opa, opb;
  logic [1:0]                      sh, sh_q;
  logic [cossim_pkg::ProdBits-1:0] prod_q;
  logic                            pend_q;
  logic [AB-1:0]                   acc_q, acc_d, addend;

  logic                    out_valid_q;
  cossim_pkg::cossim_out_t out_q, out_d;
  logic [FB-1:0]           sim;

  // element products
  always_comb begin
    a   = cossim_pkg::sext_elem(in_data_i.elem_a);
    b   = cossim_pkg::sext_elem(in_data_i.elem_b);
    pab = a * b;
    paa = a * a;
    pbb = b * b;
  end

  always_comb begin
    dot_d = dot_q;
    na_d  = na_q;
    nb_d  = nb_q;
    if (cmd_i.clr_sums) begin
      dot_d = '0;
      na_d  = '0;
      nb_d  = '0;
    end else if (cmd_i.acc_en) begin
      dot_d = dot_q + DB'(pab);
      na_d  = na_q + NB'(paa);
      nb_d  = nb_q + NB'(pbb);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
    end else begin
      dot_q <= dot_d;
      na_q  <= na_d;
      nb_q  <= nb_d;
    end
  end

  assign neg   = dot_q[DB-1];
  assign mag_d = neg ? (~dot_q + DB'(1)) : dot_q;

  // operand selection for the shared multiplier, sh is the limb weight
  always_comb begin
    opa = '0;
    opb = '0;
    sh  = 2'd0;
    case (cmd_i.mul_op)
      cossim_pkg::MO_P00: begin
        opa = na_q[LB-1:0];
        opb = nb_q[LB-1:0];
        sh  = 2'd0;
      end
      cossim_pkg::MO_P01: begin
        opa = na_q[LB-1:0];
        opb = LB'(nb_q[NB-1:LB]);
        sh  = 2'd1;
      end
      cossim_pkg::MO_P10: begin
        opa = LB'(na_q[NB-1:LB]);
        opb = nb_q[LB-1:0];
        sh  = 2'd1;
      end
      cossim_pkg::MO_P11: begin
        opa = LB'(na_q[NB-1:LB]);
        opb = LB'(nb_q[NB-1:LB]);
        sh  = 2'd2;
      end
      cossim_pkg::MO_R00: begin
        opa = mag_q[LB-1:0];
        opb = mag_q[LB-1:0];
        sh  = 2'd0;
      end
      cossim_pkg::MO_R01: begin
        opa = mag_q[LB-1:0];
        opb = LB'(mag_q[DB-1:LB]);
        sh  = 2'd1;
      end
      cossim_pkg::MO_R10: begin
        opa = LB'(mag_q[DB-1:LB]);
        opb = mag_q[LB-1:0];
        sh  = 2'd1;
      end
      cossim_pkg::MO_R11: begin
        opa = LB'(mag_q[DB-1:LB]);
        opb = LB'(mag_q[DB-1:LB]);
        sh  = 2'd2;
      end
      cossim_pkg::MO_L0: begin
        opa = sq_q;
        opb = p_q[LB-1:0];
        sh  = 2'd0;
      end
      cossim_pkg::MO_L1: begin
        opa = sq_q;
        opb = p_q[2*LB-1:LB];
        sh  = 2'd1;
      end
      cossim_pkg::MO_L2: begin
        opa = sq_q;
        opb = LB'(p_q[cossim_pkg::PBits-1:2*LB]);
        sh  = 2'd2;
      end
      default: begin
        opa = '0;
        opb = '0;
        sh  = 2'd0;
      end
    endcase
  end

  // product registered, added into the long accumulator in the next cycle
  always_comb begin
    case (sh_q)
      2'd0:    addend = AB'(prod_q);
      2'd1:    addend = AB'({prod_q, {LB{1'b0}}});
      default: addend = {prod_q[AB-2*LB-1:0], {(2*LB){1'b0}}};
    endcase
    acc_d = acc_q;
    if (cmd_i.clr_acc) begin
      acc_d = '0;
    end else if (pend_q) begin
      acc_d = acc_q + addend;
    end
  end

  // ratio search: trial bit on top of k, test (2k-1)^2 * p <= r * 2^32
  always_comb begin
    cand    = k_q | (KB'(1) << cmd_i.bit_idx);
    cand_ok = (cand <= KB'(cossim_pkg::KMax));
    odd_w   = {cand, 1'b0} - (KB+1)'(1);
    sq_d    = odd_w[KB-1:0] * odd_w[KB-1:0];
    fits    = ({2'b00, acc_q} <= {r_q, {LB{1'b0}}});
    k_d     = k_q;
    if (cmd_i.clr_k) begin
      k_d = '0;
    end else if (cmd_i.compare && cand_ok && fits) begin
      k_d = cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      acc_q  <= '0;
      k_q    <= '0;
    end else begin
      pend_q <= cmd_i.mul_en;
      acc_q  <= acc_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh;
    prod_q <= opa * opb;
    if (cmd_i.latch_mag) begin
      mag_q <= mag_d;
    end
    if (cmd_i.latch_p) begin
      p_q <= acc_q[cossim_pkg::PBits-1:0];
    end
    if (cmd_i.latch_r) begin
      r_q <= acc_q[cossim_pkg::RBits-1:0];
    end
    if (cmd_i.latch_sq) begin
      sq_q <= sq_d;
    end
  end

  // result: zero on a zero norm, negate for a negative dot, clip +1 to the largest code
  assign stat_o.zero_norm = (na_q == '0) || (nb_q == '0);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    if (stat_o.zero_norm) begin
      sim = '0;
    end else if (neg) begin
      sim = ~k_q + KB'(1);
    end else if (k_q > KB'(cossim_pkg::SatMax)) begin
      sim = KB'(cossim_pkg::SatMax);
    end else begin
      sim = k_q;
    end
    out_d.similarity = sim;
    out_d.zero_norm  = stat_o.zero_norm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPLY(a_k_range, clk_i, rst_ni, 1'b1, k_q <= KB'(cossim_pkg::KMax), "ratio above one")
  `ASSERT_IMPLY(a_zero_out, clk_i, rst_ni, out_valid_q && out_q.zero_norm, out_q.similarity == '0, "zero norm with nonzero result")
  `ASSERT_NEXT(a_sums_cleared, clk_i, rst_ni, cmd_i.load_out, dot_q == '0 && na_q == '0 && nb_q == '0, "sums not cleared after result")

endmodule

`default_nettype wire

// ----- design/cossim_ctrl.sv -----
// ----------------------------------------------------------------------------
// cossim_ctrl
// sequencer for accumulation, long products and the bitwise ratio search
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cossim_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_last_i,
  input  cossim_pkg::cossim_stat_t stat_i,
  output logic                     in_stall_o,
  output cossim_pkg::cossim_cmd_t  cmd_o
);

  localparam int SB = cossim_pkg::StepBits;
  localparam int IB = cossim_pkg::BitIdxBits;

  cossim_pkg::cossim_state_e state_q, state_d;
  logic [SB-1:0]             step_q, step_d;
  logic [IB-1:0]             bit_q, bit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cossim_pkg::ST_ACCUM;
      step_q  <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      bit_q   <= bit_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    bit_d   = bit_q;
    case (state_q)
      cossim_pkg::ST_ACCUM: begin
        if (in_valid_i && in_last_i) begin
          state_d = cossim_pkg::ST_CHECK;
        end
      end
      cossim_pkg::ST_CHECK: begin
        step_d = '0;
        if (stat_i.zero_norm) begin
          state_d = cossim_pkg::ST_DONE;
        end else begin
          state_d = cossim_pkg::ST_MUL_P;
        end
      end
      cossim_pkg::ST_MUL_P: begin
        if (step_q == SB'(cossim_pkg::NumProdPR)) begin
          state_d = cossim_pkg::ST_LATCH_P;
        end else begin
          step_d = step_q + SB'(1);
        end
      end
      cossim_pkg::ST_LATCH_P: begin
        step_d  = '0;
        state_d = cossim_pkg::ST_MUL_R;
      end
      cossim_pkg::ST_MUL_R: begin
        if (step_q == SB'(cossim_pkg::NumProdPR)) begin
          state_d = cossim_pkg::ST_LATCH_R;
        end else begin
          step_d = step_q + SB'(1);
        end
      end
      cossim_pkg::ST_LATCH_R: begin
        bit_d   = '1;
        state_d = cossim_pkg::ST_SQUARE;
      end
      cossim_pkg::ST_SQUARE: begin
        step_d  = '0;
        state_d = cossim_pkg::ST_MUL_L;
      end
      cossim_pkg::ST_MUL_L: begin
        if (step_q == SB'(cossim_pkg::NumProdL)) begin
          state_d = cossim_pkg::ST_COMPARE;
        end else begin
          step_d = step_q + SB'(1);
        end
      end
      cossim_pkg::ST_COMPARE: begin
        if (bit_q == '0) begin
          state_d = cossim_pkg::ST_DONE;
        end else begin
          bit_d   = bit_q - IB'(1);
          state_d = cossim_pkg::ST_SQUARE;
        end
      end
      cossim_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = cossim_pkg::ST_ACCUM;
        end
      end
      default: begin
        state_d = cossim_pkg::ST_ACCUM;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_op  = cossim_pkg::MO_P00;
    cmd_o.bit_idx = bit_q;
    in_stall_o    = (state_q != cossim_pkg::ST_ACCUM);
    case (state_q)
      cossim_pkg::ST_ACCUM: begin
        cmd_o.acc_en = in_valid_i;
      end
      cossim_pkg::ST_CHECK: begin
        cmd_o.latch_mag = 1'b1;
        cmd_o.clr_k     = 1'b1;
        cmd_o.clr_acc   = 1'b1;
      end
      cossim_pkg::ST_MUL_P: begin
        cmd_o.mul_en = (step_q < SB'(cossim_pkg::NumProdPR));
        case (step_q[1:0])
          2'd0:    cmd_o.mul_op = cossim_pkg::MO_P00;
          2'd1:    cmd_o.mul_op = cossim_pkg::MO_P01;
          2'd2:    cmd_o.mul_op = cossim_pkg::MO_P10;
          default: cmd_o.mul_op = cossim_pkg::MO_P11;
        endcase
      end
      cossim_pkg::ST_LATCH_P: begin
        cmd_o.latch_p = 1'b1;
        cmd_o.clr_acc = 1'b1;
      end
      cossim_pkg::ST_MUL_R: begin
        cmd_o.mul_en = (step_q < SB'(cossim_pkg::NumProdPR));
        case (step_q[1:0])
          2'd0:    cmd_o.mul_op = cossim_pkg::MO_R00;
          2'd1:    cmd_o.mul_op = cossim_pkg::MO_R01;
          2'd2:    cmd_o.mul_op = cossim_pkg::MO_R10;
          default: cmd_o.mul_op = cossim_pkg::MO_R11;
        endcase
      end
      cossim_pkg::ST_LATCH_R: begin
        cmd_o.latch_r = 1'b1;
        cmd_o.clr_acc = 1'b1;
      end
      cossim_pkg::ST_SQUARE: begin
        cmd_o.latch_sq = 1'b1;
        cmd_o.clr_acc  = 1'b1;
      end
      cossim_pkg::ST_MUL_L: begin
        cmd_o.mul_en = (step_q < SB'(cossim_pkg::NumProdL));
        case (step_q[1:0])
          2'd0:    cmd_o.mul_op = cossim_pkg::MO_L0;
          2'd1:    cmd_o.mul_op = cossim_pkg::MO_L1;
          default: cmd_o.mul_op = cossim_pkg::MO_L2;
        endcase
      end
      cossim_pkg::ST_COMPARE: begin
        cmd_o.compare = 1'b1;
      end
      cossim_pkg::ST_DONE: begin
        cmd_o.load_out = stat_i.out_free;
        cmd_o.clr_sums = stat_i.out_free;
      end
      default: begin
        cmd_o.clr_acc = 1'b1;
      end
    endcase
  end

  `ASSERT_NEXT(a_search_end, clk_i, rst_ni, state_q == cossim_pkg::ST_COMPARE && bit_q == '0, state_q == cossim_pkg::ST_DONE, "search did not finish after last bit")
  `ASSERT_IMPLY(a_step_l, clk_i, rst_ni, state_q == cossim_pkg::ST_MUL_L, step_q <= SB'(cossim_pkg::NumProdL), "limb step overrun")

endmodule

`default_nettype wire
